FILE: rtl/dce_pkg.sv
package dce_pkg;

    // sizing
    localparam int COLUMN_BITS = 16;
    localparam int MAX_TAB     = 16;
    localparam int CFG_BITS    = 5;
    localparam int TAB_BITS    = $clog2(MAX_TAB + 1);
    localparam int MAX_RES     = (MAX_TAB > 4) ? MAX_TAB : 4;
    localparam int CNT_BITS    = $clog2(MAX_RES + 1);
    localparam int IDX_BITS    = $clog2(COLUMN_BITS);

    localparam logic [CFG_BITS-1:0] TAB_WIDTH_RESET = CFG_BITS'(8);

    typedef logic [COLUMN_BITS-1:0] column_t;
    typedef logic [TAB_BITS-1:0]    tab_t;
    typedef logic [CNT_BITS-1:0]    cnt_t;
    typedef logic [IDX_BITS-1:0]    idx_t;

    // expansion kinds
    typedef logic [2:0] kind_t;
    localparam kind_t KIND_PRINT = 3'd0;
    localparam kind_t KIND_TAB   = 3'd1;
    localparam kind_t KIND_ESC   = 3'd2;
    localparam kind_t KIND_CARET = 3'd3;
    localparam kind_t KIND_OCTAL = 3'd4;

    // byte codes
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QUEST  = 8'h3f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_TILDE  = 8'h7e;
    localparam logic [7:0] CH_DEL    = 8'h7f;
    localparam logic [7:0] CTRL_BIT  = 8'h40;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mod_step;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic tab_exp;
        logic mod_done;
        logic last_char;
    } sts_t;

endpackage

FILE: rtl/display_char_expander.sv
// Display character expander: takes one raw text byte per transaction on the
// s_ side and sends its display characters on the m_ side, one character per
// transaction, with tlast on the final character of each byte. The running
// output column is cleared by the tuser flag before its byte and saturates
// at its maximum. Bytes are handled one at a time. An expanded tab first
// finds its tab stop in a remainder unit that walks the 16 column bits one
// per cycle; the output register then sends one character per cycle while
// the sink is ready. tab_width is written on the cfg channel, which is
// always ready; the user must write it only while no byte is in flight,
// which the block does not enforce. Values above 16 act as 16 and zero
// shows a tab as \t.
module display_char_expander (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] in_byte
    input  logic                          s_tuser,  // [0] new_line
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // [7:0] out_char
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dce_pkg::CFG_BITS-1:0]  cfg_data
);
    import dce_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // sequencing
    dce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // expansion, column and remainder logic
    dce_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_byte   (s_tdata),
        .new_line  (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

FILE: rtl/dce_ctrl.sv
module dce_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  dce_pkg::sts_t sts,
    output dce_pkg::cmd_t cmd
);
    import dce_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       valid_reg, valid_next;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg && !m_tready;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.tab_exp ? ST_MOD : ST_EMIT;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                if (sts.mod_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!valid_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    valid_next = 1'b1;
                    if (sts.last_char) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

FILE: rtl/dce_datapath.sv
module dce_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [7:0]                    in_byte,
    input  logic                          new_line,
    input  logic                          cfg_valid,
    input  logic [dce_pkg::CFG_BITS-1:0]  cfg_data,
    input  dce_pkg::cmd_t                 cmd,
    output dce_pkg::sts_t                 sts,
    output logic [7:0]                    out_char,
    output logic                          out_last
);
    import dce_pkg::*;

    logic [CFG_BITS-1:0] tab_width_reg;
    column_t             column_reg;
    logic [7:0]          byte_reg;
    kind_t               kind_reg;
    cnt_t                n_reg;
    cnt_t                k_reg;
    tab_t                rem_reg;
    idx_t                idx_reg;
    logic [7:0]          char_reg;
    logic                last_reg;

    tab_t                tw;
    kind_t               kind_in;
    cnt_t                n_in;
    logic [TAB_BITS:0]   trial;
    tab_t                rem_new;
    logic [7:0]          char_k;
    logic [7:0]          esc_letter;
    logic [COLUMN_BITS:0] col_sum;

    // effective tab width, saturated at the largest stop
    always_comb begin
        if (int'(tab_width_reg) > MAX_TAB) begin
            tw = TAB_BITS'(MAX_TAB);
        end else begin
            tw = TAB_BITS'(tab_width_reg);
        end
    end

    // classify the incoming byte
    always_comb begin
        if (in_byte >= CH_SPACE && in_byte <= CH_TILDE) begin
            kind_in = KIND_PRINT;
            n_in    = CNT_BITS'(1);
        end else if (in_byte == CH_TAB && tw != '0) begin
            kind_in = KIND_TAB;
            n_in    = CNT_BITS'(1);
        end else if (in_byte == CH_TAB || in_byte == CH_LF || in_byte == CH_CR
                     || in_byte == CH_BS) begin
            kind_in = KIND_ESC;
            n_in    = CNT_BITS'(2);
        end else if (in_byte < CH_SPACE || in_byte == CH_DEL) begin
            kind_in = KIND_CARET;
            n_in    = CNT_BITS'(2);
        end else begin
            kind_in = KIND_OCTAL;
            n_in    = CNT_BITS'(4);
        end
    end

    // one remainder bit per cycle, column msb first
    always_comb begin
        trial = {rem_reg, column_reg[idx_reg]};
        if (trial >= {1'b0, tw}) begin
            rem_new = TAB_BITS'(trial - {1'b0, tw});
        end else begin
            rem_new = TAB_BITS'(trial);
        end
    end

    // letter after the backslash
    always_comb begin
        case (byte_reg)
            CH_LF:   esc_letter = CH_LOW_N;
            CH_CR:   esc_letter = CH_LOW_R;
            CH_TAB:  esc_letter = CH_LOW_T;
            default: esc_letter = CH_LOW_B;
        endcase
    end

    // character at position k of the expansion
    always_comb begin
        case (kind_reg)
            KIND_PRINT: char_k = byte_reg;
            KIND_TAB:   char_k = CH_SPACE;
            KIND_ESC:   char_k = (k_reg == '0) ? CH_BSLASH : esc_letter;
            KIND_CARET: begin
                if (k_reg == '0) begin
                    char_k = CH_CARET;
                end else if (byte_reg == CH_DEL) begin
                    char_k = CH_QUEST;
                end else begin
                    char_k = byte_reg | CTRL_BIT;
                end
            end
            KIND_OCTAL: begin
                if (k_reg == '0) begin
                    char_k = CH_BSLASH;
                end else if (k_reg == CNT_BITS'(1)) begin
                    char_k = CH_ZERO + {6'd0, byte_reg[7:6]};
                end else if (k_reg == CNT_BITS'(2)) begin
                    char_k = CH_ZERO + {5'd0, byte_reg[5:3]};
                end else begin
                    char_k = CH_ZERO + {5'd0, byte_reg[2:0]};
                end
            end
            default: char_k = byte_reg;
        endcase
    end

    // saturating column advance
    assign col_sum = {1'b0, column_reg} + (COLUMN_BITS + 1)'(n_reg);

    assign sts.tab_exp   = (kind_in == KIND_TAB);
    assign sts.mod_done  = (idx_reg == '0);
    assign sts.last_char = (k_reg == n_reg - CNT_BITS'(1));

    // configuration and column state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_width_reg <= TAB_WIDTH_RESET;
            column_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                tab_width_reg <= cfg_data;
            end
            if (cmd.load && new_line) begin
                column_reg <= '0;
            end else if (cmd.emit && sts.last_char) begin
                column_reg <= col_sum[COLUMN_BITS] ? '1 : col_sum[COLUMN_BITS-1:0];
            end
        end
    end

    // item registers, remainder unit and output register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= in_byte;
            kind_reg <= kind_in;
            n_reg    <= n_in;
            k_reg    <= '0;
            rem_reg  <= '0;
            idx_reg  <= IDX_BITS'(COLUMN_BITS - 1);
        end
        if (cmd.mod_step) begin
            rem_reg <= rem_new;
            idx_reg <= idx_reg - IDX_BITS'(1);
            if (idx_reg == '0) begin
                n_reg <= CNT_BITS'(tw - rem_new);
            end
        end
        if (cmd.emit) begin
            char_reg <= char_k;
            last_reg <= sts.last_char;
            k_reg    <= k_reg + CNT_BITS'(1);
        end
    end

    assign out_char = char_reg;
    assign out_last = last_reg;

endmodule
